[rtl/lscs_pkg.sv]
// Shared constants, types and the CRC byte step for the log slot CRC scanner.
package lscs_pkg;

  // Slot geometry
  localparam int SLOT_BYTES = 64;
  localparam int SLOT_COUNT = 32;
  localparam int POS_W      = $clog2(SLOT_BYTES);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Text may end no later than this position; the stored CRC follows it
  localparam int TEXT_LIMIT = SLOT_BYTES - 3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [4:0]       slot_idx_t;
  typedef logic [5:0]       free_slot_t;
  typedef logic [1:0]       crc_cnt_t;

  // Request held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       start_scan;
  } lscs_item_t;

  // CRC-16/CCITT-FALSE, one byte, table-free form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ (x >> 4);
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
           ^ {8'h00, x};
  endfunction

endpackage

[rtl/lscs_if.sv]
// Handshake channels for the scanner: byte input and slot result output.
interface lscs_in_if import lscs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_scan;

  modport source(output valid, output data_byte, output start_scan, input ready);
  modport sink(input valid, input data_byte, input start_scan, output ready);
endinterface

interface lscs_out_if import lscs_pkg::*; ();
  logic       valid;
  logic       ready;
  slot_idx_t  slot_index;
  logic       slot_valid;
  logic       slot_empty;
  logic       scan_done;
  free_slot_t next_free_slot;

  modport source(output valid, output slot_index, output slot_valid,
                 output slot_empty, output scan_done, output next_free_slot,
                 input ready);
  modport sink(input valid, input slot_index, input slot_valid,
               input slot_empty, input scan_done, input next_free_slot,
               output ready);
endinterface

[rtl/lscs_in_stage.sv]
// Input register: captures one byte request and holds it until the engine takes it.
module lscs_in_stage import lscs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lscs_in_if.sink     in_ch,
  input  logic        take,
  output lscs_item_t  item
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       start_r;

  // Free when empty or when the held request leaves this cycle
  assign in_ch.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r  <= in_ch.data_byte;
      start_r <= in_ch.start_scan;
    end
  end

  assign item = '{valid: valid_r, data_byte: data_r, start_scan: start_r};

endmodule

[rtl/lscs_slot_engine.sv]
// Scan state, per-byte CRC/terminator update and the slot result register.
module lscs_slot_engine import lscs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lscs_item_t  item,
  output logic        take,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  lscs_out_if.source  out_ch
);

  // Scan state
  pos_t        pos_r,   pos_nxt;
  logic [15:0] crc_r,   crc_nxt;
  logic        term_r,  term_nxt;
  logic        real_r,  real_nxt;
  logic [15:0] cap_r,   cap_nxt;
  crc_cnt_t    ntk_r,   ntk_nxt;
  logic        fbz_r,   fbz_nxt;
  cnt_t        cnt_r,   cnt_nxt;
  logic        stop_r,  stop_nxt;
  logic        req_term_r;

  // Result register
  logic        out_valid_r;
  slot_idx_t   idx_r,   idx_nxt;
  logic        sval_r,  sval_nxt;
  logic        semp_r,  semp_nxt;
  logic        done_r,  done_nxt;
  free_slot_t  free_r,  free_nxt;
  logic        emit;

  // Process the held request once the result register has room
  assign take = item.valid && (!out_valid_r || out_ch.ready);

  // One byte of scan work
  always_comb begin
    logic [7:0] b;
    logic       ok;
    b        = item.data_byte;
    pos_nxt  = item.start_scan ? '0 : pos_r;
    crc_nxt  = item.start_scan ? CRC_INIT : crc_r;
    term_nxt = item.start_scan ? 1'b0 : term_r;
    real_nxt = item.start_scan ? 1'b0 : real_r;
    cap_nxt  = item.start_scan ? '0 : cap_r;
    ntk_nxt  = item.start_scan ? '0 : ntk_r;
    fbz_nxt  = item.start_scan ? 1'b0 : fbz_r;
    cnt_nxt  = item.start_scan ? '0 : cnt_r;
    stop_nxt = item.start_scan ? 1'b0 : stop_r;
    emit     = 1'b0;
    ok       = 1'b0;
    idx_nxt  = slot_idx_t'(cnt_nxt);
    sval_nxt = 1'b0;
    semp_nxt = 1'b0;
    done_nxt = 1'b0;
    free_nxt = '0;

    if (!stop_nxt) begin
      if (pos_nxt == '0) begin
        fbz_nxt = (b == 8'h00);
      end
      // CRC over text, then capture of the stored CRC, high byte first
      if (!term_nxt) begin
        crc_nxt = crc_byte(crc_nxt, b);
        if (b == 8'h00 && pos_nxt < pos_t'(TEXT_LIMIT)) begin
          term_nxt = 1'b1;
          real_nxt = 1'b1;
        end else if (pos_nxt >= pos_t'(TEXT_LIMIT)) begin
          term_nxt = 1'b1;
          real_nxt = 1'b0;
        end
      end else if (ntk_nxt < 2'd2) begin
        cap_nxt = {cap_nxt[7:0], b};
        ntk_nxt = ntk_nxt + 2'd1;
      end

      if (pos_nxt != pos_t'(SLOT_BYTES - 1)) begin
        pos_nxt = pos_nxt + pos_t'(1);
      end else begin
        // Slot end: judge it and report
        ok = !fbz_nxt && (ntk_nxt == 2'd2) && (crc_nxt == cap_nxt) &&
             (!req_term_r || real_nxt);
        idx_nxt  = slot_idx_t'(cnt_nxt);
        semp_nxt = fbz_nxt;
        sval_nxt = ok;
        if (ok) begin
          cnt_nxt  = cnt_nxt + cnt_t'(1);
          done_nxt = (cnt_nxt >= cnt_t'(SLOT_COUNT));
        end else begin
          done_nxt = 1'b1;
        end
        free_nxt = free_slot_t'(cnt_nxt);
        stop_nxt = done_nxt;
        emit     = 1'b1;
        pos_nxt  = '0;
        crc_nxt  = CRC_INIT;
        term_nxt = 1'b0;
        real_nxt = 1'b0;
        cap_nxt  = '0;
        ntk_nxt  = '0;
        fbz_nxt  = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= CRC_INIT;
      term_r     <= 1'b0;
      real_r     <= 1'b0;
      cap_r      <= '0;
      ntk_r      <= '0;
      fbz_r      <= 1'b0;
      cnt_r      <= '0;
      stop_r     <= 1'b1;
      req_term_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        req_term_r <= cfg_wdata;
      end
      if (take) begin
        pos_r  <= pos_nxt;
        crc_r  <= crc_nxt;
        term_r <= term_nxt;
        real_r <= real_nxt;
        cap_r  <= cap_nxt;
        ntk_r  <= ntk_nxt;
        fbz_r  <= fbz_nxt;
        cnt_r  <= cnt_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      idx_r  <= idx_nxt;
      sval_r <= sval_nxt;
      semp_r <= semp_nxt;
      done_r <= done_nxt;
      free_r <= free_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.slot_index     = idx_r;
  assign out_ch.slot_valid     = sval_r;
  assign out_ch.slot_empty     = semp_r;
  assign out_ch.scan_done      = done_r;
  assign out_ch.next_free_slot = free_r;

endmodule

[rtl/log_slot_crc_scanner_top.sv]
// Log slot CRC scanner: top level joining the input register and the slot engine.
// The last byte of a slot is held in the input register; the engine then writes its
// result into the result register once that register has room.
// Throughput: one byte per cycle; the input register and the result register
// decouple the two channels, so the stream stalls only while a result waits.
// Reset (rst_n low, synchronous): scan stopped until a byte with start_scan,
// require_terminator cleared, no result pending.
module log_slot_crc_scanner_top import lscs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lscs_in_if.sink     in_ch,
  lscs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  lscs_item_t item;
  logic       take;

  lscs_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .item  (item)
  );

  lscs_slot_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .take      (take),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

  // A free result side never blocks the byte stream
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while result side ready");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // An empty slot is never reported valid
  a_empty_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.slot_valid && out_ch.slot_empty))
    else $error("slot both valid and empty");

  // A rejected slot always ends the scan
  a_bad_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.slot_valid) |-> out_ch.scan_done)
    else $error("bad slot did not stop the scan");

endmodule

[tb/sv/slot_report_checker.sv]
// Slot report checker: predicts scanner results from accepted requests and compares them.
`timescale 1ns / 100ps

module slot_report_checker import lscs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lscs_in_if   in_ch,
  lscs_out_if  out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatch_count,
  output int   reports_pending
);

  typedef struct packed {
    slot_idx_t  slot_index;
    logic       slot_valid;
    logic       slot_empty;
    logic       scan_done;
    free_slot_t next_free_slot;
  } slot_report_t;

  slot_report_t expected_reports[$];
  int           reports_seen;

  // Predicted scan state
  pos_t        slot_pos;
  logic [15:0] crc_acc;
  logic        text_ended;
  logic        end_was_zero;
  logic [15:0] crc_stored;
  crc_cnt_t    crc_taken;
  logic        empty_slot;
  cnt_t        good_slots;
  logic        halted;
  logic        need_term;

  // CRC-16/CCITT-FALSE, bit-serial
  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic void clear_slot_state();
    slot_pos     = '0;
    crc_acc      = CRC_INIT;
    text_ended   = 1'b0;
    end_was_zero = 1'b0;
    crc_stored   = '0;
    crc_taken    = '0;
    empty_slot   = 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] slot report %0d: %s", $time, reports_seen, what);
    mismatch_count++;
  endtask

  // One byte of the slot stream; the last byte of a slot yields a report
  function automatic void predict_slot_byte(input logic [7:0] b, input logic st);
    slot_report_t rpt;
    logic         ok;
    if (st) begin
      clear_slot_state();
      good_slots = '0;
      halted     = 1'b0;
    end
    if (halted) return;

    if (slot_pos == '0) empty_slot = (b == 8'h00);

    if (!text_ended) begin
      crc_acc = crc16_ccitt_step(crc_acc, b);
      if (b == 8'h00 && slot_pos < TEXT_LIMIT) begin
        text_ended   = 1'b1;
        end_was_zero = 1'b1;
      end else if (slot_pos >= TEXT_LIMIT) begin
        // zero at the limit still counts as unterminated text
        text_ended   = 1'b1;
        end_was_zero = 1'b0;
      end
    end else if (crc_taken < 2) begin
      crc_stored = {crc_stored[7:0], b};
      crc_taken  = crc_taken + 1'b1;
    end

    if (slot_pos != pos_t'(SLOT_BYTES - 1)) begin
      slot_pos = slot_pos + 1'b1;
      return;
    end

    ok = !empty_slot && crc_taken == 2 && crc_acc == crc_stored &&
         (!need_term || end_was_zero);
    rpt.slot_index = slot_idx_t'(good_slots);
    rpt.slot_valid = ok;
    rpt.slot_empty = empty_slot;
    if (ok) begin
      good_slots    = good_slots + 1'b1;
      rpt.scan_done = (good_slots >= SLOT_COUNT);
    end else begin
      rpt.scan_done = 1'b1;
    end
    rpt.next_free_slot = free_slot_t'(good_slots);
    halted = rpt.scan_done;
    clear_slot_state();
    expected_reports.push_back(rpt);
  endfunction

  task automatic check_report();
    slot_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("report with none expected");
    end else begin
      want = expected_reports.pop_front();
      if (out_ch.slot_index !== want.slot_index)
        report_mismatch($sformatf("slot_index got %0d expected %0d",
                                  out_ch.slot_index, want.slot_index));
      if (out_ch.slot_valid !== want.slot_valid)
        report_mismatch($sformatf("slot_valid got %0b expected %0b",
                                  out_ch.slot_valid, want.slot_valid));
      if (out_ch.slot_empty !== want.slot_empty)
        report_mismatch($sformatf("slot_empty got %0b expected %0b",
                                  out_ch.slot_empty, want.slot_empty));
      if (out_ch.scan_done !== want.scan_done)
        report_mismatch($sformatf("scan_done got %0b expected %0b",
                                  out_ch.scan_done, want.scan_done));
      if (out_ch.next_free_slot !== want.next_free_slot)
        report_mismatch($sformatf("next_free_slot got %0d expected %0d",
                                  out_ch.next_free_slot, want.next_free_slot));
    end
    reports_seen++;
  endtask

  // Watch both channels and the register port at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_slot_state();
      good_slots = '0;
      halted     = 1'b1;
      need_term  = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_we) need_term = cfg_wdata;
      if (out_ch.valid && out_ch.ready) check_report();
      if (in_ch.valid && in_ch.ready) predict_slot_byte(in_ch.data_byte, in_ch.start_scan);
    end
    reports_pending <= expected_reports.size();
  end

endmodule

[tb/sv/log_slot_crc_scanner_top_test.sv]
// Top of the scanner testbench: clock, reset, slot stream stimulus and verdict.
`timescale 1ns / 100ps

module log_slot_crc_scanner_top_test import lscs_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 60;

  typedef enum int {
    SLOT_TEXT,       // terminated text, good CRC
    SLOT_FULL_TEXT,  // no terminator before the limit, good CRC
    SLOT_EMPTY,
    SLOT_BAD_CRC,
    SLOT_NOISE
  } slot_kind_e;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   mismatch_count;
  int   reports_pending;

  int   src_idle_pct;
  int   snk_stall_pct;
  int   bytes_sent;
  int   idle_cycles;
  logic need_term;
  logic [7:0] slot_img [SLOT_BYTES];

  int src_idle_by_phase [4] = '{0, 64, 0, 35};
  int snk_stall_by_phase [4] = '{0, 0, 64, 35};

  lscs_in_if  in_ch();
  lscs_out_if out_ch();

  log_slot_crc_scanner_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  slot_report_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: too long without any request moving ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("log_slot_crc_scanner_top regression: fail");
        $finish;
      end
    end
  end

  // Fill slot_img with one slot of the given kind
  task automatic build_slot(input slot_kind_e kind, input int text_end, input bit limit_zero);
    logic [15:0] crc;
    int          last;
    for (int i = 0; i < SLOT_BYTES; i++) slot_img[i] = 8'($urandom_range(255));
    if (kind == SLOT_EMPTY) slot_img[0] = 8'h00;
    if (kind == SLOT_EMPTY || kind == SLOT_NOISE) return;

    last = (kind == SLOT_FULL_TEXT) ? TEXT_LIMIT : text_end;
    for (int i = 0; i < last; i++)
      if (slot_img[i] == 8'h00) slot_img[i] = 8'($urandom_range(255, 1));
    if (kind != SLOT_FULL_TEXT || limit_zero)
      slot_img[last] = 8'h00;
    else if (slot_img[last] == 8'h00)
      slot_img[last] = 8'($urandom_range(255, 1));

    crc = CRC_INIT;
    for (int i = 0; i <= last; i++) crc = crc_byte(crc, slot_img[i]);
    if (kind == SLOT_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(15));
    // stored CRC, high byte first; anything after it is filler
    slot_img[last + 1] = crc[15:8];
    slot_img[last + 2] = crc[7:0];
  endtask

  // One byte request, with random source gaps
  task automatic push_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.start_scan <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_slot(input bit new_scan, input int n_bytes);
    for (int i = 0; i < n_bytes; i++) push_byte(slot_img[i], new_scan && i == 0);
  endtask

  // Stop sending and let every outstanding report come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (reports_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_require_terminator(input logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    need_term = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One scan: mostly good slots, ended by a bad one, a restart or running out
  task automatic random_scan(input int good_slots);
    slot_kind_e kind;
    int         n_slots;
    int         r;
    int         te;
    n_slots = (good_slots > 0) ? good_slots + 1 : $urandom_range(6, 1);
    for (int s = 0; s < n_slots; s++) begin
      r = $urandom_range(99);
      if (s < good_slots) kind = SLOT_TEXT;
      else if (r < 70)    kind = SLOT_TEXT;
      else if (r < 80)    kind = SLOT_FULL_TEXT;
      else if (r < 87)    kind = SLOT_EMPTY;
      else if (r < 94)    kind = SLOT_BAD_CRC;
      else                kind = SLOT_NOISE;

      r = $urandom_range(99);
      if (r < 20)      te = 1;
      else if (r < 30) te = TEXT_LIMIT - 1;
      else             te = $urandom_range(TEXT_LIMIT - 1, 1);
      build_slot(kind, te, 1'($urandom_range(1)));

      // broken sequence: next scan restarts in the middle of this slot
      if (good_slots == 0 && $urandom_range(99) < 5) begin
        send_slot(s == 0, $urandom_range(SLOT_BYTES - 1, 1));
        return;
      end
      send_slot(s == 0, SLOT_BYTES);
      if (!(kind == SLOT_TEXT || (kind == SLOT_FULL_TEXT && !need_term))) break;
    end
    // stray bytes after the scan, normally ignored
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(10, 1)) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    int phase_end;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.start_scan = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    bytes_sent       = 0;
    idle_cycles      = 0;
    need_term        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle after reset: bytes without start are dropped
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);

    // Zero at the limit, shortest and longest text, then an empty slot stops
    build_slot(SLOT_FULL_TEXT, 0, 1'b1);
    send_slot(1'b1, SLOT_BYTES);
    build_slot(SLOT_TEXT, 1, 1'b0);
    send_slot(1'b0, SLOT_BYTES);
    build_slot(SLOT_TEXT, TEXT_LIMIT - 1, 1'b0);
    send_slot(1'b0, SLOT_BYTES);
    build_slot(SLOT_EMPTY, 0, 1'b0);
    send_slot(1'b0, SLOT_BYTES);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);

    // Restart mid-slot, then a bad CRC stops the scan
    build_slot(SLOT_TEXT, 20, 1'b0);
    send_slot(1'b1, 10);
    build_slot(SLOT_TEXT, 5, 1'b0);
    send_slot(1'b1, SLOT_BYTES);
    build_slot(SLOT_BAD_CRC, 30, 1'b0);
    send_slot(1'b0, SLOT_BYTES);

    // Terminator required: unterminated text is rejected, zero at limit too
    write_require_terminator(1'b1);
    build_slot(SLOT_TEXT, 12, 1'b0);
    send_slot(1'b1, SLOT_BYTES);
    build_slot(SLOT_FULL_TEXT, 0, 1'b1);
    send_slot(1'b0, SLOT_BYTES);
    build_slot(SLOT_FULL_TEXT, 0, 1'b0);
    send_slot(1'b1, SLOT_BYTES);

    // Random phases under the different idling patterns
    for (int p = 0; p < 4; p++) begin
      write_require_terminator(logic'(p % 2));
      src_idle_pct  = src_idle_by_phase[p];
      snk_stall_pct = snk_stall_by_phase[p];
      phase_end = bytes_sent + PHASE_BYTES;
      // every slot of a scan valid, then one more byte stream past the end
      if (p == 0) random_scan(SLOT_COUNT);
      while (bytes_sent < phase_end) random_scan(0);
    end

    drain();
    if (mismatch_count == 0)
      $display("log_slot_crc_scanner_top regression: pass");
    else
      $display("log_slot_crc_scanner_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/lscs_pkg.sv
rtl/lscs_if.sv
rtl/lscs_in_stage.sv
rtl/lscs_slot_engine.sv
rtl/log_slot_crc_scanner_top.sv
tb/sv/slot_report_checker.sv
tb/sv/log_slot_crc_scanner_top_test.sv
